// ===== sv/msbp_pkg.sv =====
// msbp_pkg: shared types and constants for the MIDI serial byte parser.
// No dependencies; imported by every other file of the block but msbp_if.
package msbp_pkg;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned TICK_W     = 16;

  localparam logic REG_SENSE_TIMEOUT = 1'b0;
  localparam logic REG_LED_TIMEOUT   = 1'b1;

  localparam logic [TICK_W-1:0] SENSE_TIMEOUT_RST = 16'd300;
  localparam logic [TICK_W-1:0] LED_TIMEOUT_RST   = 16'd50;
  localparam logic [TICK_W-1:0] TICK_MAX          = 16'hFFFF;

  // Input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Special MIDI bytes
  localparam logic [7:0] MIDI_SYSEX_START  = 8'hF0;
  localparam logic [7:0] MIDI_SYSEX_END    = 8'hF7;
  localparam logic [7:0] MIDI_ACTIVE_SENSE = 8'hFE;
  localparam logic [7:0] SYSEX_ID_REBOOT   = 8'h7D;
  localparam logic [7:0] SYSEX_CMD_REBOOT  = 8'h00;
  // status C0..DF carries a single data byte
  localparam logic [2:0] STATUS_TWO_BYTE_TOP = 3'b110;

  localparam logic [2:0] SYSEX_LEN_MAX    = 3'd7;
  localparam logic [2:0] SYSEX_LEN_REBOOT = 3'd4;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Class of an accepted item, decided by the front end
  typedef enum logic [2:0] {
    CLS_TICK,
    CLS_DATA,
    CLS_CHAN,
    CLS_SYSEX_START,
    CLS_SYSEX_END,
    CLS_COMMON,
    CLS_SENSE,
    CLS_REALTIME
  } cls_e;

  typedef enum logic [2:0] {
    EVT_NONE     = 3'd0,
    EVT_CHANNEL  = 3'd1,
    EVT_REALTIME = 3'd2,
    EVT_SYSEX    = 3'd3,
    EVT_ALL_OFF  = 3'd4
  } evt_kind_e;

  typedef struct packed {
    cls_e       cls;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    evt_kind_e  event_kind;
    logic [7:0] byte_value;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic       sysex_last;
    logic       reboot_request;
    logic       led_lit;
  } result_t;

  typedef struct packed {
    logic [TICK_W-1:0] sense_timeout;
    logic [TICK_W-1:0] led_timeout;
  } cfg_t;

endpackage

// ===== sv/msbp_if.sv =====
// Channel interfaces of the MIDI serial byte parser: input items and results.
// Valid/ready handshake; payload widths follow the package field widths.
interface msbp_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;

  modport source(output valid, opcode, data_byte, input ready);
  modport sink(input valid, opcode, data_byte, output ready);
endinterface

interface msbp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] byte_value;
  logic [6:0] first_data;
  logic [6:0] second_data;
  logic       sysex_last;
  logic       reboot_request;
  logic       led_lit;

  modport source(output valid, event_kind, byte_value, first_data, second_data,
                 sysex_last, reboot_request, led_lit, input ready);
  modport sink(input valid, event_kind, byte_value, first_data, second_data,
               sysex_last, reboot_request, led_lit, output ready);
endinterface

// ===== sv/msbp_front.sv =====
// msbp_front: accepts input transactions and classifies each byte or tick.
// Depends on msbp_pkg and msbp_in_if; pushes classified items into the queue.
module msbp_front import msbp_pkg::*; (
  msbp_in_if.sink in_if,
  input  logic    q_full_i,
  output logic    push_o,
  output item_t   item_o
);

  cls_e cls;

  always_comb begin
    if (in_if.opcode == OP_TICK) begin
      cls = CLS_TICK;
    end else begin
      case (in_if.data_byte) inside
        [8'h00:8'h7F]:     cls = CLS_DATA;
        [8'h80:8'hEF]:     cls = CLS_CHAN;
        MIDI_SYSEX_START:  cls = CLS_SYSEX_START;
        MIDI_SYSEX_END:    cls = CLS_SYSEX_END;
        MIDI_ACTIVE_SENSE: cls = CLS_SENSE;
        [8'hF8:8'hFF]:     cls = CLS_REALTIME;
        default:           cls = CLS_COMMON;
      endcase
    end
  end

  assign in_if.ready      = ~q_full_i;
  assign push_o           = in_if.valid & ~q_full_i;
  assign item_o.cls       = cls;
  assign item_o.data_byte = in_if.data_byte;

endmodule

// ===== sv/msbp_queue.sv =====
// msbp_queue: short register queue between classifier and executor.
// Depends on msbp_pkg (item_t, QUEUE_DEPTH).
module msbp_queue import msbp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t                  mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < QUEUE_CNT_W'(QUEUE_DEPTH)))
    else $error("queue written while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("queue read while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== sv/msbp_back.sv =====
// msbp_back: parser state, sysex tracking, sense/LED tick counters, result register.
// Depends on msbp_pkg and msbp_out_if; pops classified items from the queue.
module msbp_back import msbp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    q_valid_i,
  input  item_t   item_i,
  output logic    pop_o,
  msbp_out_if.source out_if
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DATA1,
    PH_DATA2,
    PH_SYSEX
  } phase_e;

  phase_e            phase_q, phase_d, phase_eff;
  logic [7:0]        status_q, status_d;
  logic [6:0]        held_q, held_d;
  logic [2:0]        sx_len_q, sx_len_d, sx_len_inc;
  logic              sx_id_q, sx_id_d;
  logic              sx_cmd_q, sx_cmd_d;
  logic              armed_q, armed_d;
  logic [TICK_W-1:0] sense_q, sense_d;
  logic              led_on_q, led_on_d;
  logic [TICK_W-1:0] led_el_q, led_el_d;
  logic              out_valid_q;
  result_t           res_q, res_d;
  logic [7:0]        b;

  // executor advances when the result register is free or being drained
  assign pop_o = q_valid_i & (~out_valid_q | out_if.ready);
  assign b     = item_i.data_byte;

  assign sx_len_inc = (sx_len_q < SYSEX_LEN_MAX) ? sx_len_q + 1'b1 : sx_len_q;

  always_comb begin
    phase_d  = phase_q;
    status_d = status_q;
    held_d   = held_q;
    sx_len_d = sx_len_q;
    sx_id_d  = sx_id_q;
    sx_cmd_d = sx_cmd_q;
    armed_d  = armed_q;
    sense_d  = sense_q;
    led_on_d = led_on_q;
    led_el_d = led_el_q;
    res_d    = '0;
    res_d.event_kind = EVT_NONE;

    // a status byte in place of data aborts the partial message
    phase_eff = phase_q;
    if ((phase_q == PH_DATA1 || phase_q == PH_DATA2) && item_i.cls != CLS_DATA) begin
      phase_eff = PH_IDLE;
    end

    if (pop_o) begin
      if (item_i.cls == CLS_TICK) begin
        sense_d  = (sense_q == TICK_MAX) ? sense_q : sense_q + 1'b1;
        led_el_d = (led_el_q == TICK_MAX) ? led_el_q : led_el_q + 1'b1;
        if (led_on_q && led_el_d >= cfg_i.led_timeout) begin
          led_on_d = 1'b0;
        end
        if (armed_q && sense_d >= cfg_i.sense_timeout) begin
          armed_d = 1'b0;
          res_d.event_kind = EVT_ALL_OFF;
        end
      end else if (phase_q == PH_SYSEX) begin
        if (sx_len_q == 3'd1) begin
          sx_id_d = (b == SYSEX_ID_REBOOT);
        end else if (sx_len_q == 3'd2) begin
          sx_cmd_d = (b == SYSEX_CMD_REBOOT);
        end
        sx_len_d = sx_len_inc;
        res_d.event_kind = EVT_SYSEX;
        res_d.byte_value = b;
        if (item_i.cls == CLS_SYSEX_END) begin
          res_d.sysex_last     = 1'b1;
          res_d.reboot_request = (sx_len_inc >= SYSEX_LEN_REBOOT) & sx_id_q & sx_cmd_q;
          phase_d  = PH_IDLE;
          sx_len_d = '0;
          sx_id_d  = 1'b0;
          sx_cmd_d = 1'b0;
        end
      end else begin
        phase_d = phase_eff;
        case (phase_eff)
          PH_IDLE: begin
            case (item_i.cls)
              CLS_CHAN: begin
                status_d = b;
                phase_d  = PH_DATA1;
              end
              CLS_SENSE: begin
                sense_d = '0;
                armed_d = 1'b1;
              end
              CLS_REALTIME: begin
                sense_d  = '0;
                led_on_d = 1'b1;
                led_el_d = '0;
                res_d.event_kind = EVT_REALTIME;
                res_d.byte_value = b;
              end
              CLS_SYSEX_START: begin
                phase_d  = PH_SYSEX;
                sx_len_d = 3'd1;
                sx_id_d  = 1'b0;
                sx_cmd_d = 1'b0;
                res_d.event_kind = EVT_SYSEX;
                res_d.byte_value = b;
              end
              default: ;  // stray data and system common bytes
            endcase
          end
          PH_DATA1: begin
            if (status_q[7:5] == STATUS_TWO_BYTE_TOP) begin
              res_d.event_kind = EVT_CHANNEL;
              res_d.byte_value = status_q;
              res_d.first_data = b[6:0];
              phase_d  = PH_IDLE;
              sense_d  = '0;
              led_on_d = 1'b1;
              led_el_d = '0;
            end else begin
              held_d  = b[6:0];
              phase_d = PH_DATA2;
            end
          end
          PH_DATA2: begin
            res_d.event_kind  = EVT_CHANNEL;
            res_d.byte_value  = status_q;
            res_d.first_data  = held_q;
            res_d.second_data = b[6:0];
            phase_d  = PH_IDLE;
            sense_d  = '0;
            led_on_d = 1'b1;
            led_el_d = '0;
          end
          default: ;
        endcase
      end
    end
    res_d.led_lit = led_on_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      status_q    <= '0;
      held_q      <= '0;
      sx_len_q    <= '0;
      sx_id_q     <= 1'b0;
      sx_cmd_q    <= 1'b0;
      armed_q     <= 1'b0;
      sense_q     <= '0;
      led_on_q    <= 1'b0;
      led_el_q    <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      phase_q  <= phase_d;
      status_q <= status_d;
      held_q   <= held_d;
      sx_len_q <= sx_len_d;
      sx_id_q  <= sx_id_d;
      sx_cmd_q <= sx_cmd_d;
      armed_q  <= armed_d;
      sense_q  <= sense_d;
      led_on_q <= led_on_d;
      led_el_q <= led_el_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
        res_q       <= res_d;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.event_kind     = res_q.event_kind;
  assign out_if.byte_value     = res_q.byte_value;
  assign out_if.first_data     = res_q.first_data;
  assign out_if.second_data    = res_q.second_data;
  assign out_if.sysex_last     = res_q.sysex_last;
  assign out_if.reboot_request = res_q.reboot_request;
  assign out_if.led_lit        = res_q.led_lit;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.reboot_request) |-> res_q.sysex_last)
    else $error("reboot flagged off the last sysex byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_SYSEX) |-> (sx_len_q == '0 && !sx_id_q && !sx_cmd_q))
    else $error("sysex tracking left over outside a run");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && res_d.event_kind == EVT_ALL_OFF) |=> !armed_q)
    else $error("sense timeout still armed after all sound off");

endmodule

// ===== sv/midi_serial_byte_parser.sv =====
// Top level of the MIDI serial byte parser: APB config registers and the
// front end, queue and executor. Depends on msbp_pkg, msbp_if, msbp_front, msbp_queue and msbp_back.
// Each accepted transaction is registered in the queue and then in the result register.
// Throughput: one item per cycle while results are taken; every accepted item yields exactly one result.
// Ready drops only when the 2-entry queue is full (result side stalled).
// Reset (rst_ni low, async): parser idle, counters and flags cleared,
// timeouts back to 300 and 50 ticks; no clearing pass.
module midi_serial_byte_parser import msbp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // APB-style configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // byte / tick transactions in, event transactions out
  msbp_in_if.sink               midi_i,
  msbp_out_if.source            evt_o
);

  cfg_t  cfg_q;
  logic  reg_sel;
  logic  cfg_wr;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_valid;
  item_t push_item;
  item_t pop_item;

  // word address: register i at byte 4*i
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sense_timeout <= SENSE_TIMEOUT_RST;
      cfg_q.led_timeout   <= LED_TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_SENSE_TIMEOUT: cfg_q.sense_timeout <= pwdata[TICK_W-1:0];
        REG_LED_TIMEOUT:   cfg_q.led_timeout   <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SENSE_TIMEOUT: prdata = APB_DATA_W'(cfg_q.sense_timeout);
      REG_LED_TIMEOUT:   prdata = APB_DATA_W'(cfg_q.led_timeout);
      default:           prdata = '0;
    endcase
  end

  // front end: classify each byte/tick as it is accepted
  msbp_front u_front (
    .in_if    (midi_i),
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (push_item)
  );

  // decouples input acceptance from result back-pressure
  msbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  // executor: parse state, timers and the result register
  msbp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .item_i    (pop_item),
    .pop_o     (pop),
    .out_if    (evt_o)
  );

endmodule

// ===== tb/tb_midi_serial_byte_parser.sv =====
// Self-checking testbench for midi_serial_byte_parser: directed table, then
// randomized MIDI traffic under several timeout settings, checked by a predictor.
// Depends on msbp_pkg, msbp_if and the midi_serial_byte_parser RTL.
module tb_midi_serial_byte_parser;
  import msbp_pkg::*;

  localparam int CLK_PERIOD      = 4;
  localparam int RESET_CYCLES    = 10;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TIMEOUT_CYCLES  = 1000000;
  localparam int ITEMS_PER_PHASE = 330;
  localparam int HOLD_CYCLES     = 200;      // long receiver stall
  localparam int IDLE_PCT        = 20;
  localparam int MAX_REPORTS     = 10;

  // Random phases, each with its own timeout pair
  localparam int NUM_PHASES  = 6;
  localparam int PH_HOLDOFF  = 2;            // receiver stalls, sender floods
  localparam int PH_RANDOM   = 3;            // random timeouts, sender pauses midway
  localparam int PH_NO_IDLE  = 4;            // neither side idles

  localparam logic [7:0] MIDI_REALTIME_MIN = 8'hF8;

  typedef enum logic [1:0] {
    WAIT_STATUS,
    WAIT_DATA1,
    WAIT_DATA2,
    IN_SYSEX
  } parse_phase_e;

  // One directed transaction; res is used only where typed is set
  typedef struct packed {
    logic    op;
    logic [7:0] data;
    logic    typed;
    result_t res;
  } dir_row_t;

  localparam result_t QUIET_DARK = '{EVT_NONE, 8'h00, 7'h00, 7'h00, 1'b0, 1'b0, 1'b0};
  localparam result_t QUIET_LIT  = '{EVT_NONE, 8'h00, 7'h00, 7'h00, 1'b0, 1'b0, 1'b1};

  localparam int NUM_ROWS = 27;

  // Runs right after reset with the default timeouts; no tick follows the
  // first row, so the LED stays lit from the first completed message on.
  dir_row_t directed_rows [NUM_ROWS] = '{
    '{OP_TICK, 8'h00, 1'b1, QUIET_DARK},  // tick, nothing armed
    '{OP_BYTE, 8'h00, 1'b1, QUIET_DARK},  // stray data byte while idle
    '{OP_BYTE, 8'hF1, 1'b1, QUIET_DARK},  // stray system common
    '{OP_BYTE, 8'hF7, 1'b1, QUIET_DARK},  // stray end of sysex
    '{OP_BYTE, 8'h90, 1'b1, QUIET_DARK},
    '{OP_BYTE, 8'h7F, 1'b1, QUIET_DARK},
    '{OP_BYTE, 8'h7F, 1'b1, '{EVT_CHANNEL, 8'h90, 7'h7F, 7'h7F, 1'b0, 1'b0, 1'b1}},
    '{OP_BYTE, 8'h7F, 1'b1, QUIET_LIT},   // no running status
    '{OP_BYTE, 8'hC0, 1'b0, QUIET_LIT},
    '{OP_BYTE, 8'h00, 1'b1, '{EVT_CHANNEL, 8'hC0, 7'h00, 7'h00, 1'b0, 1'b0, 1'b1}},
    '{OP_BYTE, 8'hDF, 1'b0, QUIET_LIT},
    // two-byte message: second data field must be zero
    '{OP_BYTE, 8'h7F, 1'b1, '{EVT_CHANNEL, 8'hDF, 7'h7F, 7'h00, 1'b0, 1'b0, 1'b1}},
    '{OP_BYTE, 8'hEF, 1'b0, QUIET_LIT},
    '{OP_BYTE, 8'h80, 1'b0, QUIET_LIT},   // status aborts, parsed afresh
    '{OP_BYTE, 8'h12, 1'b0, QUIET_LIT},
    '{OP_BYTE, 8'h34, 1'b1, '{EVT_CHANNEL, 8'h80, 7'h12, 7'h34, 1'b0, 1'b0, 1'b1}},
    '{OP_BYTE, 8'h90, 1'b0, QUIET_LIT},
    // real-time aborts the partial message and passes through
    '{OP_BYTE, 8'hF8, 1'b1, '{EVT_REALTIME, 8'hF8, 7'h00, 7'h00, 1'b0, 1'b0, 1'b1}},
    '{OP_BYTE, 8'hFF, 1'b1, '{EVT_REALTIME, 8'hFF, 7'h00, 7'h00, 1'b0, 1'b0, 1'b1}},
    '{OP_BYTE, 8'hFE, 1'b1, QUIET_LIT},   // active sense: arm only
    // reboot sysex
    '{OP_BYTE, 8'hF0, 1'b1, '{EVT_SYSEX, 8'hF0, 7'h00, 7'h00, 1'b0, 1'b0, 1'b1}},
    '{OP_BYTE, 8'h7D, 1'b1, '{EVT_SYSEX, 8'h7D, 7'h00, 7'h00, 1'b0, 1'b0, 1'b1}},
    '{OP_BYTE, 8'h00, 1'b1, '{EVT_SYSEX, 8'h00, 7'h00, 7'h00, 1'b0, 1'b0, 1'b1}},
    '{OP_BYTE, 8'hF7, 1'b1, '{EVT_SYSEX, 8'hF7, 7'h00, 7'h00, 1'b1, 1'b1, 1'b1}},
    // status inside sysex is just payload; not a reboot
    '{OP_BYTE, 8'hF0, 1'b0, QUIET_LIT},
    '{OP_BYTE, 8'h90, 1'b0, QUIET_LIT},
    '{OP_BYTE, 8'hF7, 1'b0, QUIET_LIT}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  msbp_in_if  midi_bus();
  msbp_out_if evt_bus();

  midi_serial_byte_parser dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .midi_i  (midi_bus),
    .evt_o   (evt_bus)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Predictor state, mirrors the parser after each accepted transaction
  cfg_t              cfg_m;
  parse_phase_e      phase_m;
  logic [7:0]        status_m;
  logic [6:0]        data1_m;
  logic [2:0]        sx_len_m;
  logic              sx_id_m;
  logic              sx_cmd_m;
  logic              armed_m;
  logic [TICK_W-1:0] sense_cnt_m;
  logic [TICK_W-1:0] led_cnt_m;
  logic              led_m;

  result_t expected_events_q [$];

  int mismatch_count  = 0;
  int reg_read_errors = 0;
  int midi_idle_pct   = IDLE_PCT;
  int sink_idle_pct   = IDLE_PCT;
  int hold_requests   = 0;

  // Any completed message or passed real-time byte counts as traffic.
  function automatic void note_activity();
    sense_cnt_m = '0;
    led_m       = 1'b1;
    led_cnt_m   = '0;
  endfunction

  function automatic result_t predict_event(input logic op, input logic [7:0] b);
    result_t r;
    r = QUIET_DARK;
    if (op == OP_TICK) begin
      if (sense_cnt_m != TICK_MAX) sense_cnt_m++;
      if (led_cnt_m != TICK_MAX) led_cnt_m++;
      if (led_m && led_cnt_m >= cfg_m.led_timeout) led_m = 1'b0;
      if (armed_m && sense_cnt_m >= cfg_m.sense_timeout) begin
        armed_m      = 1'b0;
        r.event_kind = EVT_ALL_OFF;
      end
    end else if (phase_m == IN_SYSEX) begin
      // every byte up to F7 is streamed, whatever it is
      if (sx_len_m == 3'd1) sx_id_m = (b == SYSEX_ID_REBOOT);
      else if (sx_len_m == 3'd2) sx_cmd_m = (b == SYSEX_CMD_REBOOT);
      if (sx_len_m < SYSEX_LEN_MAX) sx_len_m++;
      r.event_kind = EVT_SYSEX;
      r.byte_value = b;
      if (b == MIDI_SYSEX_END) begin
        r.sysex_last     = 1'b1;
        r.reboot_request = (sx_len_m >= SYSEX_LEN_REBOOT) && sx_id_m && sx_cmd_m;
        phase_m  = WAIT_STATUS;
        sx_len_m = '0;
        sx_id_m  = 1'b0;
        sx_cmd_m = 1'b0;
      end
    end else begin
      if (phase_m != WAIT_STATUS && b[7]) phase_m = WAIT_STATUS;
      case (phase_m)
        WAIT_STATUS: begin
          if (b[7] && b < MIDI_SYSEX_START) begin
            status_m = b;
            phase_m  = WAIT_DATA1;
          end else if (b >= MIDI_REALTIME_MIN) begin
            sense_cnt_m = '0;
            if (b == MIDI_ACTIVE_SENSE) begin
              armed_m = 1'b1;
            end else begin
              note_activity();
              r.event_kind = EVT_REALTIME;
              r.byte_value = b;
            end
          end else if (b == MIDI_SYSEX_START) begin
            phase_m      = IN_SYSEX;
            sx_len_m     = 3'd1;
            sx_id_m      = 1'b0;
            sx_cmd_m     = 1'b0;
            r.event_kind = EVT_SYSEX;
            r.byte_value = b;
          end
        end
        WAIT_DATA1: begin
          if (status_m[7:5] == STATUS_TWO_BYTE_TOP) begin
            r.event_kind = EVT_CHANNEL;
            r.byte_value = status_m;
            r.first_data = b[6:0];
            phase_m      = WAIT_STATUS;
            note_activity();
          end else begin
            data1_m = b[6:0];
            phase_m = WAIT_DATA2;
          end
        end
        default: begin
          r.event_kind  = EVT_CHANNEL;
          r.byte_value  = status_m;
          r.first_data  = data1_m;
          r.second_data = b[6:0];
          phase_m       = WAIT_STATUS;
          note_activity();
        end
      endcase
    end
    r.led_lit = led_m;
    return r;
  endfunction

  // Offer one item, random idle cycles first; returns at the accepting edge
  // with the predicted event queued.
  task automatic send_midi(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < midi_idle_pct) begin
      midi_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    midi_bus.valid     <= 1'b1;
    midi_bus.opcode    <= op;
    midi_bus.data_byte <= b;
    do @(posedge clk_i); while (!midi_bus.ready);
    expected_events_q.insert(expected_events_q.size(), predict_event(op, b));
  endtask

  // Stop offering and wait for every outstanding event, then let it settle.
  task automatic drain_events();
    midi_bus.valid <= 1'b0;
    while (expected_events_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_read_check(input logic reg_idx, input logic [TICK_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DATA_W'(want)) begin
      reg_read_errors++;
      if (reg_read_errors <= MAX_REPORTS)
        $display("register %0d readback: expected %h, got %h", reg_idx, want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write a timeout register, mirror it in the predictor, read it back.
  task automatic cfg_write(input logic reg_idx, input logic [TICK_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= APB_DATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_idx == REG_SENSE_TIMEOUT) cfg_m.sense_timeout = val;
    else cfg_m.led_timeout = val;
    cfg_read_check(reg_idx, val);
  endtask

  // Event receiver: checks each accepted transaction against the oldest
  // prediction and drives ready, with random stalls and on request a long
  // hold-off counted here.
  initial begin
    result_t seen;
    result_t want;
    int      holds_served;
    int      stall_left;
    holds_served  = 0;
    stall_left    = 0;
    evt_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && evt_bus.valid && evt_bus.ready) begin
        seen = '{evt_kind_e'(evt_bus.event_kind), evt_bus.byte_value, evt_bus.first_data,
                 evt_bus.second_data, evt_bus.sysex_last, evt_bus.reboot_request,
                 evt_bus.led_lit};
        if (expected_events_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected event: kind=%0d byte=%h", seen.event_kind, seen.byte_value);
        end else begin
          want = expected_events_q.pop_front();
          if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("event mismatch: expected kind=%0d byte=%h d1=%h d2=%h last=%b rb=%b led=%b",
                       want.event_kind, want.byte_value, want.first_data, want.second_data,
                       want.sysex_last, want.reboot_request, want.led_lit);
              $display("                got      kind=%0d byte=%h d1=%h d2=%h last=%b rb=%b led=%b",
                       seen.event_kind, seen.byte_value, seen.first_data, seen.second_data,
                       seen.sysex_last, seen.reboot_request, seen.led_lit);
            end
          end
        end
      end
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        stall_left   = HOLD_CYCLES;
        evt_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        evt_bus.ready <= 1'b0;
      end else begin
        evt_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Stimulus: reset, directed table, random phases.
  initial begin
    logic [8:0]        burst [$];
    logic [7:0]        st;
    logic [7:0]        x;
    logic [TICK_W-1:0] sense_val;
    logic [TICK_W-1:0] led_val;
    int                pick;
    int                n;
    int                sent;
    bit                paused;

    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    midi_bus.valid     = 1'b0;
    midi_bus.opcode    = OP_BYTE;
    midi_bus.data_byte = '0;

    cfg_m       = '{SENSE_TIMEOUT_RST, LED_TIMEOUT_RST};
    phase_m     = WAIT_STATUS;
    status_m    = '0;
    data1_m     = '0;
    sx_len_m    = '0;
    sx_id_m     = 1'b0;
    sx_cmd_m    = 1'b0;
    armed_m     = 1'b0;
    sense_cnt_m = '0;
    led_cnt_m   = '0;
    led_m       = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Timeouts come out of reset at their defaults
    cfg_read_check(REG_SENSE_TIMEOUT, SENSE_TIMEOUT_RST);
    cfg_read_check(REG_LED_TIMEOUT, LED_TIMEOUT_RST);

    // Typed rows replace the prediction with the value written in the table;
    // the predictor still runs so its state keeps up.
    foreach (directed_rows[i]) begin
      send_midi(directed_rows[i].op, directed_rows[i].data);
      if (directed_rows[i].typed)
        expected_events_q[expected_events_q.size() - 1] = directed_rows[i].res;
    end
    drain_events();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:          begin sense_val = 16'd1;    led_val = 16'd1;  end
        1:          begin sense_val = 16'd0;    led_val = 16'd0;  end  // fire on next tick
        PH_HOLDOFF: begin sense_val = 16'd3;    led_val = 16'd5;  end
        PH_RANDOM:  begin
          sense_val = TICK_W'($urandom_range(40, 2));
          led_val   = TICK_W'($urandom_range(40, 2));
        end
        PH_NO_IDLE: begin sense_val = TICK_MAX; led_val = TICK_MAX; end
        default:    begin sense_val = SENSE_TIMEOUT_RST; led_val = LED_TIMEOUT_RST; end
      endcase
      cfg_write(REG_SENSE_TIMEOUT, sense_val);
      cfg_write(REG_LED_TIMEOUT, led_val);

      midi_idle_pct = (ph == PH_NO_IDLE || ph == PH_HOLDOFF) ? 0 : IDLE_PCT;
      sink_idle_pct <= (ph == PH_NO_IDLE) ? 0 : IDLE_PCT;
      if (ph == PH_HOLDOFF) hold_requests <= hold_requests + 1;

      sent   = 0;
      paused = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst.delete();
        pick = $urandom_range(99);
        if (pick < 30) begin
          // well-formed channel message
          st = 8'($urandom_range(8'hEF, 8'h80));
          burst.insert(burst.size(), {OP_BYTE, st});
          burst.insert(burst.size(), {OP_BYTE, 1'b0, 7'($urandom)});
          if (st[7:5] != STATUS_TWO_BYTE_TOP)
            burst.insert(burst.size(), {OP_BYTE, 1'b0, 7'($urandom)});
        end else if (pick < 55) begin
          n = $urandom_range(8, 1);
          repeat (n) burst.insert(burst.size(), {OP_TICK, 8'($urandom)});
        end else if (pick < 65) begin
          // real-time, active sense half the time
          st = $urandom_range(1) ? MIDI_ACTIVE_SENSE : 8'($urandom_range(8'hFF, 8'hF8));
          burst.insert(burst.size(), {OP_BYTE, st});
        end else if (pick < 80) begin
          burst.insert(burst.size(), {OP_BYTE, MIDI_SYSEX_START});
          if ($urandom_range(2) == 0) begin
            burst.insert(burst.size(), {OP_BYTE, SYSEX_ID_REBOOT});
            burst.insert(burst.size(), {OP_BYTE, SYSEX_CMD_REBOOT});
            n = $urandom_range(5, 0);
          end else begin
            n = $urandom_range(9, 0);
          end
          repeat (n) begin
            x = {1'b0, 7'($urandom)};
            if ($urandom_range(4) == 0) x = 8'($urandom_range(8'hFF, 8'h80));
            if (x == MIDI_SYSEX_END) x = MIDI_REALTIME_MIN;
            burst.insert(burst.size(), {OP_BYTE, x});
          end
          burst.insert(burst.size(), {OP_BYTE, MIDI_SYSEX_END});
        end else if (pick < 90) begin
          // partial message cut short by a status or real-time byte
          burst.insert(burst.size(), {OP_BYTE, 8'($urandom_range(8'hEF, 8'h80))});
          if ($urandom_range(1)) burst.insert(burst.size(), {OP_BYTE, 1'b0, 7'($urandom)});
          burst.insert(burst.size(), {OP_BYTE, 8'($urandom_range(8'hFF, 8'h80))});
        end else begin
          burst.insert(burst.size(), {1'($urandom), 8'($urandom)});
        end

        foreach (burst[i]) begin
          send_midi(burst[i][8], burst[i][7:0]);
          sent++;
          // once the hold-off has backed up the queue, resume normal idling
          if (ph == PH_HOLDOFF && sent == 50) midi_idle_pct = IDLE_PCT;
        end
        if (ph == PH_RANDOM && !paused && sent >= ITEMS_PER_PHASE / 2) begin
          drain_events();
          paused = 1;
        end
      end
      drain_events();
    end

    if (expected_events_q.size() == 0 && mismatch_count == 0 && reg_read_errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
sv/msbp_pkg.sv
sv/msbp_if.sv
sv/msbp_front.sv
sv/msbp_queue.sv
sv/msbp_back.sv
sv/midi_serial_byte_parser.sv
tb/tb_midi_serial_byte_parser.sv
